>>> src/grbpwm_pkg.sv
// Shared types and constants for the GRB pixel to PWM duty encoder.
// No dependencies; every other file imports this package.
package grbpwm_pkg;

    localparam int unsigned BITS_PER_PIXEL = 24;
    localparam int unsigned LATCH_DEFAULT  = 50;
    localparam int unsigned LATCH_MAX      = 64;
    localparam int unsigned DUTY_W         = 16;
    localparam int unsigned SLOT_W         = 7;
    localparam int unsigned CFG_IDX_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_DUTY    = 2'd0,
        REG_ZERO_DUTY   = 2'd1,
        REG_LATCH_SLOTS = 2'd2
    } reg_index_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_LATCH = 1'b1
    } command_t;

    typedef struct packed {
        logic       command;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              last;
    } duty_out_t;

    typedef struct packed {
        logic [DUTY_W-1:0] one_duty;
        logic [DUTY_W-1:0] zero_duty;
        logic [SLOT_W-1:0] latch_slots;
    } cfg_t;

    // One classified request: bit pattern (pixel) or gap length (latch).
    typedef struct packed {
        logic                      is_latch;
        logic [BITS_PER_PIXEL-1:0] bits;
        logic [SLOT_W-1:0]         slots;
    } job_t;

endpackage

>>> src/grbpwm_front.sv
// Front stage: accepts input requests, classifies them into pixel or latch jobs.
// Depends on grbpwm_pkg.
module grbpwm_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  grbpwm_pkg::pixel_in_t  s_data,
    input  grbpwm_pkg::cfg_t       cfg,
    output logic                   job_valid,
    input  logic                   job_ready,
    output grbpwm_pkg::job_t       job
);
    import grbpwm_pkg::*;

    logic              job_valid_reg;
    logic              job_valid_next;
    job_t              job_reg;
    job_t              job_next;
    logic [SLOT_W-1:0] gap_len;
    logic              accept;

    assign s_ready   = !job_valid_reg || job_ready;
    assign accept    = s_valid && s_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    // Clamp the gap length to 1..LATCH_MAX.
    always_comb begin
        if (cfg.latch_slots == '0) begin
            gap_len = SLOT_W'(1);
        end else if (cfg.latch_slots > SLOT_W'(LATCH_MAX)) begin
            gap_len = SLOT_W'(LATCH_MAX);
        end else begin
            gap_len = cfg.latch_slots;
        end
    end

    always_comb begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        if (accept) begin
            job_valid_next = 1'b1;
            job_next.bits  = {s_data.green, s_data.red, s_data.blue};
            if (command_t'(s_data.command) == CMD_LATCH) begin
                job_next.is_latch = 1'b1;
                job_next.slots    = gap_len;
            end else begin
                job_next.is_latch = 1'b0;
                job_next.slots    = SLOT_W'(BITS_PER_PIXEL);
            end
        end else if (job_ready) begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
        end
        job_reg <= job_next;
    end

endmodule

>>> src/grbpwm_fifo.sv
// Short job queue between the front and back stages.
// Depends on grbpwm_pkg for the job type.
module grbpwm_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  grbpwm_pkg::job_t  wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output grbpwm_pkg::job_t  rd_data
);
    import grbpwm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with unequal pointers");

endmodule

>>> src/grbpwm_back.sv
// Back stage: serializes one job into duty slots through an output register.
// Depends on grbpwm_pkg.
module grbpwm_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  grbpwm_pkg::job_t       job,
    input  grbpwm_pkg::cfg_t       cfg,
    output logic                   m_valid,
    input  logic                   m_ready,
    output grbpwm_pkg::duty_out_t  m_data
);
    import grbpwm_pkg::*;

    logic                      busy_reg;
    logic                      busy_next;
    logic                      latch_reg;
    logic                      latch_next;
    logic [BITS_PER_PIXEL-1:0] bits_reg;
    logic [BITS_PER_PIXEL-1:0] bits_next;
    logic [SLOT_W-1:0]         cnt_reg;
    logic [SLOT_W-1:0]         cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    duty_out_t                 out_reg;
    duty_out_t                 out_next;
    logic                      adv;
    logic                      emit;
    logic                      last_slot;

    assign adv       = !out_valid_reg || m_ready;
    assign emit      = busy_reg && adv;
    assign last_slot = cnt_reg == SLOT_W'(1);
    // Load the next job on the same cycle the current one sends its last slot.
    assign job_ready = !busy_reg || (emit && last_slot);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        busy_next      = busy_reg;
        latch_next     = latch_reg;
        bits_next      = bits_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_next.last  = last_slot;
            if (latch_reg) begin
                out_next.duty = '0;
            end else begin
                out_next.duty = bits_reg[BITS_PER_PIXEL-1] ? cfg.one_duty : cfg.zero_duty;
            end
            bits_next = {bits_reg[BITS_PER_PIXEL-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (last_slot) begin
                busy_next = 1'b0;
            end
        end else if (adv) begin
            out_valid_next = 1'b0;
        end
        if (job_valid && job_ready) begin
            busy_next  = 1'b1;
            latch_next = job.is_latch;
            bits_next  = job.bits;
            cnt_next   = job.slots;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
        latch_reg <= latch_next;
        bits_reg  <= bits_next;
        out_reg   <= out_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0) && (cnt_reg <= SLOT_W'(LATCH_MAX)))
        else $error("slot counter out of range while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid && (m_data.last == $past(last_slot)))
        else $error("last flag does not match final slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && latch_reg |=> m_data.duty == '0)
        else $error("latch gap slot with nonzero duty");

endmodule

>>> src/grb_pixel_to_pwm_duty_encoder.sv
// Top level of the GRB pixel to PWM duty encoder: config registers, front, queue, back.
// Depends on grbpwm_pkg, grbpwm_front, grbpwm_fifo and grbpwm_back.
//
// A pixel request produces 24 duty values (green, red, blue, MSB first), one per
// clock while m_ready is high; a latch request produces latch_slots zero-duty values
// (0 counts as 1, above 64 as 64). The back-end serializer emits one slot per cycle
// while m_ready is high and loads the next queued request in the cycle it sends the
// previous run's last slot, so consecutive runs leave without gaps. Registers:
// 0 one_duty, 1 zero_duty, 2 latch_slots (reset 0, 0, 50); write them only while
// the block is idle.
module grb_pixel_to_pwm_duty_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  grbpwm_pkg::pixel_in_t                 s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output grbpwm_pkg::duty_out_t                 m_data,
    input  logic                                  cfg_we,
    input  logic [grbpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grbpwm_pkg::DUTY_W-1:0]         cfg_wdata
);
    import grbpwm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic back_valid;
    logic back_ready;
    job_t back_job;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_ONE_DUTY:    cfg_next.one_duty    = cfg_wdata;
                REG_ZERO_DUTY:   cfg_next.zero_duty   = cfg_wdata;
                REG_LATCH_SLOTS: cfg_next.latch_slots = cfg_wdata[SLOT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_duty    <= '0;
            cfg_reg.zero_duty   <= '0;
            cfg_reg.latch_slots <= SLOT_W'(LATCH_DEFAULT);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    grbpwm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg_reg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    grbpwm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_job),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_job)
    );

    grbpwm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .cfg       (cfg_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> tb/sv/grbpwm_checker.sv
// Scoreboard for the GRB pixel to PWM duty encoder: mirrors register writes,
// turns each accepted request into its expected duty slots and compares the output.
// Depends on grbpwm_pkg.
module grbpwm_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  grbpwm_pkg::pixel_in_t            s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  grbpwm_pkg::duty_out_t            m_data,
    input  logic                             cfg_we,
    input  logic [grbpwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grbpwm_pkg::DUTY_W-1:0]    cfg_wdata,
    output int                               mismatches,
    output int                               pending,
    output int                               pixel_count,
    output int                               latch_count,
    output int                               slot_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import grbpwm_pkg::*;

    localparam int REPORT_LIMIT = 10;

    duty_out_t         duty_queue[$];
    logic [DUTY_W-1:0] one_duty_q;
    logic [DUTY_W-1:0] zero_duty_q;
    logic [SLOT_W-1:0] latch_slots_q;
    int                errs = 0;
    int                pixels = 0;
    int                latches = 0;
    int                slots = 0;

    function automatic void note_failure(input string msg);
        errs++;
        if (errs <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Expand one request into the duty slots it must produce, in order.
    function automatic void encode_request(input pixel_in_t req);
        logic [BITS_PER_PIXEL-1:0] grb;
        int unsigned               gap;
        duty_out_t                 slot;
        if (req.command == CMD_LATCH) begin
            latches++;
            gap = latch_slots_q;
            if (gap == 0) gap = 1;
            if (gap > LATCH_MAX) gap = LATCH_MAX;
            for (int unsigned k = 0; k < gap; k++) begin
                slot.duty = '0;
                slot.last = (k + 1 == gap);
                duty_queue.push_back(slot);
            end
        end else begin
            pixels++;
            grb = {req.green, req.red, req.blue};
            for (int k = BITS_PER_PIXEL - 1; k >= 0; k--) begin
                slot.duty = grb[k] ? one_duty_q : zero_duty_q;
                slot.last = (k == 0);
                duty_queue.push_back(slot);
            end
        end
    endfunction

    always @(posedge aclk) begin
        duty_out_t want;
        if (!aresetn) begin
            one_duty_q    = '0;
            zero_duty_q   = '0;
            latch_slots_q = SLOT_W'(LATCH_DEFAULT);
            duty_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ONE_DUTY:    one_duty_q    = cfg_wdata;
                    REG_ZERO_DUTY:   zero_duty_q   = cfg_wdata;
                    REG_LATCH_SLOTS: latch_slots_q = cfg_wdata[SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) encode_request(s_data);
            if (m_valid && m_ready) begin
                slots++;
                if (duty_queue.size() == 0) begin
                    note_failure($sformatf("unexpected duty slot: duty %h last %b",
                                           m_data.duty, m_data.last));
                end else begin
                    want = duty_queue.pop_front();
                    if (m_data.duty !== want.duty || m_data.last !== want.last)
                        note_failure($sformatf(
                            "duty slot mismatch at %0t: expected duty %h last %b, got duty %h last %b",
                            $realtime, want.duty, want.last, m_data.duty, m_data.last));
                end
            end
        end
        pending     <= duty_queue.size();
        mismatches  <= errs;
        pixel_count <= pixels;
        latch_count <= latches;
        slot_count  <= slots;
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the encoder testbench: clock, reset, register writes, request and stall traffic.
// Depends on grbpwm_pkg, grbpwm_checker and grb_pixel_to_pwm_duty_encoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import grbpwm_pkg::*;

    localparam int                   CYCLE_LIMIT   = 400000;
    localparam int                   SETTLE_CYCLES = 8;
    localparam int                   LATCH_PCT     = 20;
    localparam int                   RANDOM_ROUNDS = 8;
    localparam int                   ROUND_ITEMS   = 44;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pixel_in_t            s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    duty_out_t            m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUTY_W-1:0]    cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int pixel_count;
    int latch_count;
    int slot_count;
    int cycle_count = 0;
    int stall_pct = 0;
    int send_idle_pct = 0;
    int settings_count = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    grb_pixel_to_pwm_duty_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    grbpwm_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (fail_count),
        .pending     (outstanding),
        .pixel_count (pixel_count),
        .latch_count (latch_count),
        .slot_count  (slot_count)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d duty slots still due", cycle_count,
                     outstanding);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic pixel_in_t make_request(input command_t cmd, input logic [7:0] g,
                                               input logic [7:0] r, input logic [7:0] b);
        pixel_in_t req;
        req.command = cmd;
        req.green   = g;
        req.red     = r;
        req.blue    = b;
        return req;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_in_t random_request();
        command_t cmd;
        cmd = ($urandom_range(99) < LATCH_PCT) ? CMD_LATCH : CMD_PIXEL;
        return make_request(cmd, pick_byte(), pick_byte(), pick_byte());
    endfunction

    // Hold valid high from one request to the next unless an idle gap is drawn.
    task automatic send_request(input pixel_in_t req);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every expected duty slot has come out.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_settings(input logic [DUTY_W-1:0] one_val,
                                  input logic [DUTY_W-1:0] zero_val,
                                  input logic [DUTY_W-1:0] slots_val);
        drain();
        write_reg(REG_ONE_DUTY, one_val);
        write_reg(REG_ZERO_DUTY, zero_val);
        write_reg(REG_LATCH_SLOTS, slots_val);
        settings_count++;
    endtask

    task automatic random_settings();
        logic [SLOT_W-1:0] slots;
        case ($urandom_range(9))
            0:       slots = '0;
            1:       slots = SLOT_W'(LATCH_MAX);
            2:       slots = SLOT_W'($urandom_range(LATCH_MAX + 1, 127));
            default: slots = SLOT_W'($urandom_range(1, 8));
        endcase
        // upper bits of the slot write are junk and must be dropped
        write_settings(16'($urandom), 16'($urandom),
                       {9'($urandom), slots});
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: all duties zero, 50 slot gap
        send_request(make_request(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(CMD_LATCH, 8'h5A, 8'hC3, 8'h81));

        // zero slot count must still give one slot
        write_settings(16'hFFFF, 16'h0000, 16'hFF80);
        send_request(make_request(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(CMD_PIXEL, 8'h00, 8'h00, 8'h00));
        send_request(make_request(CMD_PIXEL, 8'h80, 8'h01, 8'hAA));
        send_request(make_request(CMD_LATCH, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(CMD_PIXEL, 8'hAA, 8'h55, 8'hAA));
        send_request(make_request(CMD_LATCH, 8'h00, 8'h00, 8'h00));

        // oversized slot count saturates
        write_settings(16'h0000, 16'hFFFF, 16'd127);
        send_request(make_request(CMD_PIXEL, 8'h00, 8'h00, 8'h00));
        send_request(make_request(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(CMD_LATCH, 8'h12, 8'h34, 8'h56));
        send_request(make_request(CMD_LATCH, 8'hFF, 8'h00, 8'hFF));

        // a write to the unlisted index must change nothing
        write_settings(16'h1234, 16'hABCD, 16'(LATCH_MAX));
        write_reg(REG_SPARE, 16'hFFFF);
        send_request(make_request(CMD_LATCH, 8'h01, 8'h02, 8'h03));
        send_request(make_request(CMD_PIXEL, 8'h5A, 8'h3C, 8'hC3));

        write_settings(16'h8001, 16'h7FFE, 16'd1);
        send_request(make_request(CMD_LATCH, 8'h00, 8'hFF, 8'h00));
        send_request(make_request(CMD_LATCH, 8'hFF, 8'h00, 8'hFF));
        send_request(make_request(CMD_PIXEL, 8'h0F, 8'hF0, 8'h3C));

        write_settings(16'h00FF, 16'hFF00, 16'(LATCH_MAX + 1));
        send_request(make_request(CMD_LATCH, 8'h00, 8'h00, 8'h00));

        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            random_settings();
            case (round % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 77; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 77; end
                default: begin send_idle_pct = 27; stall_pct <= 27; end
            endcase
            repeat (ROUND_ITEMS) send_request(random_request());
        end

        drain();
        $display("covered %0d pixels and %0d latch gaps, %0d duty slots checked, %0d settings",
                 pixel_count, latch_count, slot_count, settings_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d duty slots never seen", fail_count, outstanding);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
src/grbpwm_pkg.sv
src/grbpwm_front.sv
src/grbpwm_fifo.sv
src/grbpwm_back.sv
src/grb_pixel_to_pwm_duty_encoder.sv
tb/sv/grbpwm_checker.sv
tb/sv/tb_top.sv
